FILE: rtl/core/two_class_quota_round_server_assert.svh
// Assertion macros used by the round server back end.
`ifndef TWO_CLASS_QUOTA_ROUND_SERVER_ASSERT_SVH
`define TWO_CLASS_QUOTA_ROUND_SERVER_ASSERT_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define TCQRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never be seen outside reset.
`define TCQRS_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define TCQRS_ASSERT(label, prop, msg)
`define TCQRS_NEVER(label, expr, msg)
`endif

`endif

FILE: rtl/core/tcqrs_pkg.sv
// Shared types and constants of the two-class quota round server.
`timescale 1ns / 1ps
`default_nettype none

package tcqrs_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int AGE_W      = 8;
  localparam int ID_W       = 16;
  localparam int GRP_W      = 2;
  localparam int QUOTA_W    = 4;
  localparam int LEFT_W     = 5;
  localparam int KIND_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_AGE_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUOTA0        = 3'd1;

  localparam logic [AGE_W-1:0]   AGE_THRESHOLD_RESET = 8'd60;
  localparam logic [QUOTA_W-1:0] QUOTA_RESET         = 4'd1;

  localparam logic CMD_SERVE = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SERVED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic             serve;
    logic [GRP_W-1:0] group;
    logic             group_ok;
    logic [ID_W-1:0]  item_id;
    logic             pri;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              accepted;
    logic [GRP_W-1:0]  served_group;
    logic [ID_W-1:0]   served_id;
    logic              from_priority;
    logic              group_last;
    logic              last;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_EMPTY
  } srv_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/tcqrs_front.sv
// Front end: takes requests, classifies them by age and group, queues them.
`timescale 1ns / 1ps
`default_nettype none

module tcqrs_front #(
  parameter int GROUPS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tcqrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcqrs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_cmd,
  input  logic [tcqrs_pkg::GRP_W-1:0]      in_group,
  input  logic [tcqrs_pkg::ID_W-1:0]       in_item_id,
  input  logic [tcqrs_pkg::AGE_W-1:0]      in_age,
  output logic                             cmd_valid,
  input  logic                             cmd_pop,
  output tcqrs_pkg::cmd_t                  cmd
);
  import tcqrs_pkg::*;

  logic [AGE_W-1:0] age_threshold;
  cmd_t             entries [2];
  cmd_t             classified;
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;

  always_ff @(posedge clk) begin
    if (rst) begin
      age_threshold <= AGE_THRESHOLD_RESET;
    end else if (cfg_we && cfg_index == REG_AGE_THRESHOLD) begin
      age_threshold <= cfg_data[AGE_W-1:0];
    end
  end

  always_comb begin
    classified.serve    = (in_cmd == CMD_SERVE);
    classified.group    = in_group;
    classified.group_ok = ({1'b0, in_group} < 3'(GROUPS));
    classified.item_id  = in_item_id;
    classified.pri      = (in_age >= age_threshold);
  end

  assign in_ready  = (count != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, cmd_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tcqrs_back.sv
// Back end: FIFO store, pointers and the serve sequencer with its output register.
`timescale 1ns / 1ps
`default_nettype none

module tcqrs_back #(
  parameter int GROUPS      = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_QUOTA   = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tcqrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcqrs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             cmd_valid,
  output logic                             cmd_pop,
  input  tcqrs_pkg::cmd_t                  cmd,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tcqrs_pkg::result_t               out_r
);
  import tcqrs_pkg::*;

  `include "two_class_quota_round_server_assert.svh"

  localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int QW = GW + 1;
  localparam int NQ = 2 ** QW;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = QW + PW;

  logic [QUOTA_W-1:0] quota     [GROUPS];
  logic [LEFT_W-1:0]  eff_quota [GROUPS];
  logic [GROUPS-1:0]  work;
  logic [FW-1:0]      fill_cnt  [NQ];
  logic [PW-1:0]      head      [NQ];
  logic [PW-1:0]      tail      [NQ];
  logic [NQ-1:0]      nonempty;
  logic [ID_W-1:0]    mem       [2 ** AW];
  logic [ID_W-1:0]    rd_data;

  srv_state_t        state, state_next;
  logic [GW-1:0]     g_cur, g_next, g_inc;
  logic              c_cur, c_next;
  logic [LEFT_W-1:0] left, left_next;
  logic              any_served, any_next;
  logic              pend_glast, pend_glast_next;
  logic              pend_last, pend_last_next;
  logic              more_in_group;
  result_t           out_next;
  logic              load_out;
  logic              slot_free;
  logic              do_enq;
  logic              do_pop;
  logic              later_work;
  logic [QW-1:0]     enq_q, scan_q, sel_q;
  logic [FW-1:0]     sel_fill;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < GROUPS; i++) begin
        quota[i] <= QUOTA_RESET;
      end
    end else if (cfg_we) begin
      for (int i = 0; i < GROUPS; i++) begin
        if (cfg_index == REG_QUOTA0 + CFG_IDX_W'(i)) begin
          quota[i] <= cfg_data[QUOTA_W-1:0];
        end
      end
    end
  end

  // Clamp each quota and flag groups that would still serve something.
  always_comb begin
    for (int i = 0; i < GROUPS; i++) begin
      eff_quota[i] = (LEFT_W'(quota[i]) > LEFT_W'(MAX_QUOTA)) ? LEFT_W'(MAX_QUOTA)
                                                               : LEFT_W'(quota[i]);
      work[i] = (eff_quota[i] != '0) && (nonempty[2*i] || nonempty[2*i+1]);
    end
  end

  always_comb begin
    for (int f = 0; f < NQ; f++) begin
      nonempty[f] = (fill_cnt[f] != '0);
    end
  end

  always_comb begin
    later_work = 1'b0;
    for (int i = 0; i < GROUPS; i++) begin
      if (GW'(i) > g_cur) begin
        later_work = later_work | work[i];
      end
    end
  end

  assign g_inc     = g_cur + 1'b1;
  assign enq_q     = {cmd.group[GW-1:0], ~cmd.pri};
  assign scan_q    = {g_cur, c_cur};
  assign sel_q     = (state == ST_IDLE) ? enq_q : scan_q;
  assign sel_fill  = fill_cnt[sel_q];
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next      = state;
    g_next          = g_cur;
    c_next          = c_cur;
    left_next       = left;
    any_next        = any_served;
    pend_glast_next = pend_glast;
    pend_last_next  = pend_last;
    more_in_group   = 1'b0;
    cmd_pop         = 1'b0;
    do_enq          = 1'b0;
    do_pop          = 1'b0;
    load_out        = 1'b0;
    out_next        = out_r;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.serve) begin
            cmd_pop    = 1'b1;
            g_next     = '0;
            c_next     = 1'b0;
            left_next  = eff_quota[0];
            any_next   = 1'b0;
            state_next = ST_SCAN;
          end else if (slot_free) begin
            cmd_pop                = 1'b1;
            do_enq                 = cmd.group_ok && (sel_fill != FW'(QUEUE_DEPTH));
            load_out               = 1'b1;
            out_next.kind          = KIND_ACK;
            out_next.accepted      = do_enq;
            out_next.served_group  = cmd.group;
            out_next.served_id     = cmd.item_id;
            out_next.from_priority = cmd.pri;
            out_next.group_last    = 1'b0;
            out_next.last          = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (left != '0 && sel_fill != '0) begin
          do_pop        = 1'b1;
          left_next     = left - 1'b1;
          // Entries still waiting in this queue, or normal ones behind the priority queue.
          more_in_group = (sel_fill != FW'(1)) || (!c_cur && nonempty[{g_cur, 1'b1}]);
          pend_glast_next = (left == LEFT_W'(1)) || !more_in_group;
          pend_last_next  = pend_glast_next && !later_work;
          state_next      = ST_EMIT;
        end else if (!c_cur) begin
          c_next = 1'b1;
        end else if (g_cur == GW'(GROUPS - 1)) begin
          state_next = any_served ? ST_IDLE : ST_EMPTY;
        end else begin
          g_next    = g_inc;
          c_next    = 1'b0;
          left_next = eff_quota[g_inc];
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          load_out               = 1'b1;
          out_next.kind          = KIND_SERVED;
          out_next.accepted      = 1'b0;
          out_next.served_group  = GRP_W'(g_cur);
          out_next.served_id     = rd_data;
          out_next.from_priority = !c_cur;
          out_next.group_last    = pend_glast;
          out_next.last          = pend_last;
          any_next               = 1'b1;
          state_next             = pend_last ? ST_IDLE : ST_SCAN;
        end
      end
      ST_EMPTY: begin
        if (slot_free) begin
          load_out               = 1'b1;
          out_next.kind          = KIND_EMPTY;
          out_next.accepted      = 1'b0;
          out_next.served_group  = '0;
          out_next.served_id     = '0;
          out_next.from_priority = 1'b0;
          out_next.group_last    = 1'b0;
          out_next.last          = 1'b1;
          state_next             = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      g_cur      <= '0;
      c_cur      <= 1'b0;
      left       <= '0;
      any_served <= 1'b0;
      pend_glast <= 1'b0;
      pend_last  <= 1'b0;
    end else begin
      state      <= state_next;
      g_cur      <= g_next;
      c_cur      <= c_next;
      left       <= left_next;
      any_served <= any_next;
      pend_glast <= pend_glast_next;
      pend_last  <= pend_last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int f = 0; f < NQ; f++) begin
        head[f]     <= '0;
        tail[f]     <= '0;
        fill_cnt[f] <= '0;
      end
    end else begin
      if (do_enq) begin
        tail[sel_q]     <= ptr_inc(tail[sel_q]);
        fill_cnt[sel_q] <= sel_fill + 1'b1;
      end
      if (do_pop) begin
        head[sel_q]     <= ptr_inc(head[sel_q]);
        fill_cnt[sel_q] <= sel_fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_enq) begin
      mem[{sel_q, tail[sel_q]}] <= cmd.item_id;
    end
    if (do_pop) begin
      rd_data <= mem[{sel_q, head[sel_q]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= out_next;
    end
  end

  `TCQRS_ASSERT(a_emit_follows_pop, (state == ST_EMIT && $past(state) != ST_EMIT) |-> $past(do_pop), "emit without a store read")
  `TCQRS_ASSERT(a_last_ends_request, (load_out && out_next.last) |=> (state == ST_IDLE), "request not finished after last result")
  `TCQRS_NEVER(a_no_overwrite, out_valid && !out_ready && load_out, "output register overwritten while stalled")

endmodule

`default_nettype wire

FILE: rtl/core/two_class_quota_round_server.sv
// Top level of the two-class quota round server.
//
//  channel  dir  handshake               payload
//  s_axis   in   tvalid/tready           tuser: cmd; tdata: group, item_id, age
//  m_axis   out  tvalid/tready           tuser: kind; tdata: result fields; tlast
//  cfg      in   cfg_we (no wait)        cfg_index, cfg_data
//
// An enqueue request is handled in the back end's idle state once it leaves the
// two-entry request queue. A serve round does a store read, then an output load, for
// each served entry, and a scan step for each queue visited without a pop.
// Synchronous reset clears pointers, counts and handshake state; no store clearing.
// A stalled m_axis holds the output register; up to two requests still queue up.
`timescale 1ns / 1ps
`default_nettype none

module two_class_quota_round_server #(
  parameter int GROUPS      = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_QUOTA   = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,  // group, item_id, age
  input  logic [0:0]                       s_axis_tuser,  // cmd
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // accepted, served_group, served_id, from_priority, group_last
  output logic [23:0]                      m_axis_tdata,
  output logic [1:0]                       m_axis_tuser,  // kind
  output logic                             m_axis_tlast,
  input  logic                             cfg_we,
  input  logic [tcqrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcqrs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tcqrs_pkg::*;

  logic    cmd_valid;
  logic    cmd_pop;
  cmd_t    cmd;
  result_t res;

  tcqrs_front #(
    .GROUPS(GROUPS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (s_axis_tuser[0]),
    .in_group   (s_axis_tdata[1:0]),
    .in_item_id (s_axis_tdata[17:2]),
    .in_age     (s_axis_tdata[25:18]),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .cmd        (cmd)
  );

  tcqrs_back #(
    .GROUPS      (GROUPS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_QUOTA   (MAX_QUOTA)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_r     (res)
  );

  assign m_axis_tdata = {3'b000, res.group_last, res.from_priority, res.served_id,
                         res.served_group, res.accepted};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

FILE: verif/two_class_quota_round_server_tb.sv
// Self-checking testbench: directed table plus random traffic against a round-server predictor.
`timescale 1ns / 1ps

module two_class_quota_round_server_tb;
  import tcqrs_pkg::*;

  localparam int GROUPS      = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_QUOTA   = 10;
  localparam int FIFOS       = GROUPS * 2;

  localparam logic CMD_ENQUEUE = 1'b0;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 15;
  // longest round: every group serving its full quota and every queue visited, with margin
  localparam int SETTLE_CYCLES   = 2 * GROUPS * MAX_QUOTA + 2 * GROUPS + 20;
  localparam int CYCLE_LIMIT     = 600000;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  grp;
    logic [15:0] id;
    logic [7:0]  age;
    logic [4:0]  reps;
    logic        lit;
    result_t     res;
  } stim_row_t;

  localparam int ROWS = 12;
  // Literal results only where they follow straight from reset or the full-queue rule.
  localparam stim_row_t DIRECTED_ROWS [ROWS] = '{
    // round on an empty server: one empty marker
    '{CMD_SERVE,   2'd0, 16'h0000, 8'd0,   5'd1,  1'b1,
      '{KIND_EMPTY, 1'b0, 2'd0, 16'h0000, 1'b0, 1'b0, 1'b1}},
    '{CMD_ENQUEUE, 2'd0, 16'hFFFF, 8'd255, 5'd1,  1'b1,
      '{KIND_ACK, 1'b1, 2'd0, 16'hFFFF, 1'b1, 1'b0, 1'b1}},
    '{CMD_ENQUEUE, 2'd3, 16'h0000, 8'd0,   5'd1,  1'b1,
      '{KIND_ACK, 1'b1, 2'd3, 16'h0000, 1'b0, 1'b0, 1'b1}},
    // age equal to the threshold goes to the priority queue, one below does not
    '{CMD_ENQUEUE, 2'd1, 16'h1234, 8'd60,  5'd1,  1'b1,
      '{KIND_ACK, 1'b1, 2'd1, 16'h1234, 1'b1, 1'b0, 1'b1}},
    '{CMD_ENQUEUE, 2'd1, 16'h5678, 8'd59,  5'd1,  1'b1,
      '{KIND_ACK, 1'b1, 2'd1, 16'h5678, 1'b0, 1'b0, 1'b1}},
    // serve fields other than cmd are ignored
    '{CMD_SERVE,   2'd3, 16'hFFFF, 8'd255, 5'd1,  1'b0, '0},
    '{CMD_SERVE,   2'd0, 16'h0000, 8'd0,   5'd1,  1'b0, '0},
    '{CMD_SERVE,   2'd2, 16'hA5A5, 8'd128, 5'd1,  1'b1,
      '{KIND_EMPTY, 1'b0, 2'd0, 16'h0000, 1'b0, 1'b0, 1'b1}},
    // fill one priority queue, then overflow it
    '{CMD_ENQUEUE, 2'd2, 16'h8000, 8'd200, 5'd16, 1'b0, '0},
    '{CMD_ENQUEUE, 2'd2, 16'h7FFF, 8'd61,  5'd1,  1'b1,
      '{KIND_ACK, 1'b0, 2'd2, 16'h7FFF, 1'b1, 1'b0, 1'b1}},
    '{CMD_ENQUEUE, 2'd2, 16'h5A5A, 8'd0,   5'd1,  1'b0, '0},
    '{CMD_SERVE,   2'd1, 16'h0F0F, 8'd7,   5'd1,  1'b0, '0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;  // group, item_id, age
  logic [0:0]           s_axis_tuser = '0;  // cmd
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // accepted, served_group, served_id, from_priority, group_last
  logic [23:0]          m_axis_tdata;
  logic [1:0]           m_axis_tuser;       // kind
  logic                 m_axis_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  logic [AGE_W-1:0]   age_limit;
  logic [QUOTA_W-1:0] serve_quota [GROUPS];
  logic [ID_W-1:0]    fifo_mem [FIFOS][QUEUE_DEPTH];
  int                 fifo_head [FIFOS];
  int                 fifo_tail [FIFOS];
  int                 fifo_fill [FIFOS];
  result_t            due_results [$];

  int mismatches = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;
  int cycle_count;

  two_class_quota_round_server #(
    .GROUPS      (GROUPS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_QUOTA   (MAX_QUOTA)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the results one accepted request causes and update the queues.
  task automatic predict_response(input logic cmd, input logic [1:0] grp,
                                  input logic [15:0] id, input logic [7:0] age,
                                  input bit keep);
    result_t batch [$];
    result_t r;
    int q;
    int left;
    int first;
    if (cmd == CMD_ENQUEUE) begin
      r = '0;
      r.kind = KIND_ACK;
      r.served_group = grp;
      r.served_id = id;
      r.from_priority = (age >= age_limit);
      r.last = 1'b1;
      q = int'(grp) * 2 + (r.from_priority ? 0 : 1);
      if (fifo_fill[q] < QUEUE_DEPTH) begin
        fifo_mem[q][fifo_tail[q]] = id;
        fifo_tail[q] = (fifo_tail[q] + 1) % QUEUE_DEPTH;
        fifo_fill[q]++;
        r.accepted = 1'b1;
      end
      batch.push_back(r);
    end else begin
      for (int g = 0; g < GROUPS; g++) begin
        left = (serve_quota[g] > MAX_QUOTA) ? MAX_QUOTA : int'(serve_quota[g]);
        first = batch.size();
        for (int c = 0; c < 2; c++) begin
          q = g * 2 + c;
          while (left > 0 && fifo_fill[q] > 0) begin
            r = '0;
            r.kind = KIND_SERVED;
            r.served_group = g[GRP_W-1:0];
            r.served_id = fifo_mem[q][fifo_head[q]];
            r.from_priority = (c == 0);
            fifo_head[q] = (fifo_head[q] + 1) % QUEUE_DEPTH;
            fifo_fill[q]--;
            left--;
            batch.push_back(r);
          end
        end
        if (batch.size() > first) batch[batch.size() - 1].group_last = 1'b1;
      end
      if (batch.size() == 0) begin
        r = '0;
        r.kind = KIND_EMPTY;
        r.last = 1'b1;
        batch.push_back(r);
      end else begin
        batch[batch.size() - 1].last = 1'b1;
      end
    end
    if (keep) foreach (batch[i]) due_results.push_back(batch[i]);
  endtask

  // Drive one request, hold it until taken, then predict it.
  task automatic issue_request(input logic cmd, input logic [1:0] grp,
                               input logic [15:0] id, input logic [7:0] age,
                               input bit keep);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, age, id, grp};
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (s_axis_tready !== 1'b1) @(posedge clk);
    predict_response(cmd, grp, id, age, keep);
  endtask

  // Hold the sender until every expected result is out and the block is quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_AGE_THRESHOLD) begin
      age_limit = val;
    end else if (idx >= REG_QUOTA0 && idx < REG_QUOTA0 + GROUPS) begin
      serve_quota[idx - REG_QUOTA0] = val[QUOTA_W-1:0];
    end
  endtask

  task automatic apply_setting(input logic [7:0] vals [GROUPS + 1], input bit junk);
    write_register(REG_AGE_THRESHOLD, vals[0]);
    for (int g = 0; g < GROUPS; g++) write_register(REG_QUOTA0 + g[CFG_IDX_W-1:0], vals[g + 1]);
    // unmapped indices must leave every register alone
    if (junk) begin
      for (int j = REG_QUOTA0 + GROUPS; j < 2 ** CFG_IDX_W; j++) begin
        write_register(j[CFG_IDX_W-1:0], 8'($urandom));
      end
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_age();
    case ($urandom_range(0, 3))
      0:       pick_age = age_limit - 8'd1;
      1:       pick_age = age_limit;
      default: pick_age = 8'($urandom);
    endcase
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // receiver: random stall bursts, none once idle_on drops
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 13);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      seen.kind          = m_axis_tuser;
      seen.accepted      = m_axis_tdata[0];
      seen.served_group  = m_axis_tdata[2:1];
      seen.served_id     = m_axis_tdata[18:3];
      seen.from_priority = m_axis_tdata[19];
      seen.group_last    = m_axis_tdata[20];
      seen.last          = m_axis_tlast;
      if (due_results.size() == 0) begin
        $error("result with nothing expected: kind %0h id %0h", seen.kind, seen.served_id);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("kind", 16'(want.kind), 16'(seen.kind));
        check_field("accepted", 16'(want.accepted), 16'(seen.accepted));
        check_field("served_group", 16'(want.served_group), 16'(seen.served_group));
        check_field("served_id", want.served_id, seen.served_id);
        check_field("from_priority", 16'(want.from_priority), 16'(seen.from_priority));
        check_field("group_last", 16'(want.group_last), 16'(seen.group_last));
        check_field("last", 16'(want.last), 16'(seen.last));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** two_class_quota_round_server: FAILED **");
    $finish;
  end

  initial begin
    logic [7:0] regs_now [GROUPS + 1];
    logic [1:0] grp;
    logic [7:0] age;
    int sent;
    int run;
    age_limit = AGE_THRESHOLD_RESET;
    for (int g = 0; g < GROUPS; g++) serve_quota[g] = QUOTA_RESET;
    for (int q = 0; q < FIFOS; q++) begin
      fifo_head[q] = 0;
      fifo_tail[q] = 0;
      fifo_fill[q] = 0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < ROWS; r++) begin
      for (int k = 0; k < DIRECTED_ROWS[r].reps; k++) begin
        issue_request(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].grp,
                      DIRECTED_ROWS[r].id + 16'(k), DIRECTED_ROWS[r].age,
                      !DIRECTED_ROWS[r].lit);
        if (DIRECTED_ROWS[r].lit) due_results.push_back(DIRECTED_ROWS[r].res);
      end
    end
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        // zero threshold, every quota at its limit (one with upper data bits set)
        0: regs_now = '{8'd0, 8'h0A, 8'hFA, 8'h0A, 8'h0A};
        // top threshold, a zero quota and a quota above the limit
        1: regs_now = '{8'd255, 8'h00, 8'h0F, 8'h01, 8'hF5};
        2: regs_now = '{8'd128, 8'h03, 8'h00, 8'h0C, 8'h02};
        default: foreach (regs_now[i]) regs_now[i] = 8'($urandom);
      endcase
      apply_setting(regs_now, p == 1);
      if (p == PHASES - 1) idle_on = 1'b0;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 5) == 0) begin
          // pile a run into one queue so full queues show up
          grp = 2'($urandom);
          age = pick_age();
          run = $urandom_range(4, 10);
          repeat (run) issue_request(CMD_ENQUEUE, grp, 16'($urandom), age, 1'b1);
          sent += run;
        end else if ($urandom_range(0, 3) == 0) begin
          issue_request(CMD_SERVE, 2'($urandom), 16'($urandom), 8'($urandom), 1'b1);
          sent++;
        end else begin
          issue_request(CMD_ENQUEUE, 2'($urandom), 16'($urandom), pick_age(), 1'b1);
          sent++;
        end
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("** two_class_quota_round_server: PASSED **");
    end else begin
      $display("** two_class_quota_round_server: FAILED **");
    end
    $finish;
  end

endmodule
